// ----- hw/rtl/spq_pkg.sv -----
// Package for the sorted max priority queue: entry and control types,
// operation and status codes, and the default depth.
// Used by spq_cell, sorted_priority_queue_max_core and spq_chk.
package spq_pkg;

  // Default number of entries held by the queue.
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Field widths of one beat.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned STAT_W = 2;

  // Operation codes carried on in_tuser.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // Status codes of a result beat.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  // One stored entry.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } spq_entry_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic       ins_en;     // accepted insert into a queue that is not full
    logic       pop_en;     // accepted pop from a queue that is not empty
    logic       new_front;  // the new entry goes to the head
    spq_entry_t new_ent;    // entry being inserted
  } spq_ctrl_t;

endpackage

// ----- hw/rtl/sorted_priority_queue_max_core.sv -----
// Sorted max priority queue built as a chain of compare-and-shift cells.
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one insert or pop per cycle while out_tready holds; each cell does one compare a cycle.
// An output register parts the two sides, so a new beat is taken in the cycle
// that a waiting result drains. Reset (rst_n low, synchronous) empties the
// queue and drops any pending result; stored entries are left as they are.
module sorted_priority_queue_max_core #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] entry_value, [63:32] entry_priority
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [31:0] front_value, [63:32] front_priority,
                                  // [68:64] occupancy, [69] queue_empty,
                                  // [71:70] status
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  spq_entry_t       out_front_r;
  logic [OCC_W-1:0] out_occ_r;
  logic             out_empty_r;
  logic [STAT_W-1:0] out_status_r, status_nxt;

  logic       accept, is_pop, full, empty;
  spq_ctrl_t  ctrl;

  logic       occ [QUEUE_DEPTH];
  logic       gt  [QUEUE_DEPTH];
  logic       ge  [QUEUE_DEPTH];
  spq_entry_t ents    [QUEUE_DEPTH];
  spq_entry_t ents_nxt[QUEUE_DEPTH];

  // Input handshake: take a beat whenever the output register is free or drains.
  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;
  assign is_pop    = (in_tuser == OP_POP);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);

  // Broadcast control for the chain. The new entry takes the head only when
  // its priority is strictly above the head's, so a tie stays behind it.
  always_comb begin
    ctrl.ins_en        = accept & ~is_pop & ~full;
    ctrl.pop_en        = accept & is_pop & ~empty;
    ctrl.new_ent.value = in_tdata[31:0];
    ctrl.new_ent.prio  = in_tdata[63:32];
    ctrl.new_front     = ~occ[0] | (~gt[0] & (ents[0].prio != ctrl.new_ent.prio));
  end

  // The chain of cells.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occ[i] = (count_r > CNT_W'(i));
    if (i == 0) begin : g_head
      spq_cell #(.HEAD_CELL(1'b1)) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .occ      (occ[i]),
        .left_ge  (1'b0),
        .left_ent (ctrl.new_ent),
        .right_ent(ents[(QUEUE_DEPTH > 1) ? 1 : 0]),
        .gt       (gt[i]),
        .ge       (ge[i]),
        .ent      (ents[i]),
        .ent_nxt  (ents_nxt[i])
      );
    end else begin : g_body
      spq_cell #(.HEAD_CELL(1'b0)) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .occ      (occ[i]),
        .left_ge  (ge[i-1]),
        .left_ent (ents[i-1]),
        .right_ent(ents[(i + 1 < QUEUE_DEPTH) ? i + 1 : i]),
        .gt       (gt[i]),
        .ge       (ge[i]),
        .ent      (ents[i]),
        .ent_nxt  (ents_nxt[i])
      );
    end
  end

  // Count update and status of the step.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    if (ctrl.ins_en) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.pop_en) begin
      count_nxt = count_r - 1'b1;
    end
    if (~is_pop & full) begin
      status_nxt = ST_OVERFLOW;
    end else if (is_pop & empty) begin
      status_nxt = ST_UNDERFLOW;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register: the front after the step, zero when the queue is empty.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_front_r  <= (count_nxt == '0) ? '0 : ents_nxt[0];
      out_occ_r    <= OCC_W'(count_nxt);
      out_empty_r  <= (count_nxt == '0);
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_status_r, out_empty_r, out_occ_r,
                       out_front_r.prio, out_front_r.value};

endmodule

// ----- hw/rtl/spq_cell.sv -----
// One cell of the sorted queue chain: holds one entry, compares it with the
// incoming priority and shifts toward its neighbors on insert or pop.
// Depends on spq_pkg.
module spq_cell #(
  parameter bit HEAD_CELL = 1'b0
) (
  input  logic                clk,
  input  spq_pkg::spq_ctrl_t  ctrl,
  input  logic                occ,       // this position holds an entry
  input  logic                left_ge,   // left neighbor is at or after the insert point
  input  spq_pkg::spq_entry_t left_ent,
  input  spq_pkg::spq_entry_t right_ent,
  output logic                gt,        // stored priority above the new priority
  output logic                ge,        // this position is at or after the insert point
  output spq_pkg::spq_entry_t ent,
  output spq_pkg::spq_entry_t ent_nxt
);
  import spq_pkg::*;

  spq_entry_t ent_r;

  // Local compare against the incoming priority.
  assign gt = ent_r.prio > ctrl.new_ent.prio;

  // The head decides the front case; deeper cells use the sorted order, so the
  // first cell that is empty or not above the new priority marks the slot.
  assign ge = HEAD_CELL ? ctrl.new_front : (ctrl.new_front | ~occ | ~gt);

  // Next entry: take from the left past the insert point, load at the insert
  // point, take from the right on a pop.
  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.ins_en) begin
      if (left_ge) begin
        ent_nxt = left_ent;
      end else if (ge) begin
        ent_nxt = ctrl.new_ent;
      end
    end else if (ctrl.pop_en) begin
      ent_nxt = right_ent;
    end
  end

  // Payload storage, no reset needed.
  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

// ----- hw/rtl/spq_chk.sv -----
// Port-level checker for sorted_priority_queue_max_core, bound to the top.
// Depends on spq_pkg.
module spq_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);
  import spq_pkg::*;

  // A stalled result beat holds its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Every accepted input beat gives a result beat in the next cycle.
  a_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat produced no result");

  // Empty flag agrees with the occupancy.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[69] == (out_tdata[68:64] == '0)))
    else $error("queue_empty disagrees with occupancy");

  // An empty queue shows a zero front.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[69] |-> (out_tdata[63:0] == '0))
    else $error("empty queue shows a nonzero front");

  // Only defined status codes appear.
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[71:70] == ST_OK || out_tdata[71:70] == ST_OVERFLOW ||
                    out_tdata[71:70] == ST_UNDERFLOW))
    else $error("undefined status code");

endmodule

bind sorted_priority_queue_max_core spq_chk u_spq_chk (.*);
